// ----- design/complex_arithmetic_unit_core_macros.svh -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Same-cycle implication.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, field offsets, operation and status codes, pipeline control type.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int CAU_DATA_WIDTH = 32;
  localparam int CAU_FRAC_BITS  = 16;

  localparam int FIELD_W    = 32;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 72;

  localparam int IN_ACT_LSB = 0;
  localparam int IN_AR_LSB  = 2;
  localparam int IN_AI_LSB  = 34;
  localparam int IN_BR_LSB  = 66;
  localparam int IN_BI_LSB  = 98;

  localparam int OUT_RR_LSB   = 0;
  localparam int OUT_RI_LSB   = 32;
  localparam int OUT_STAT_LSB = 64;

  localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SUB = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MUL = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_DIV = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DIVZ = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVF  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RSVD = 2'd3;

  typedef struct packed {
    logic                vld;
    logic                is_div;
    logic                neg_re;
    logic                neg_im;
    logic [STATUS_W-1:0] status;
  } cau_ctl_t;

endpackage

`default_nettype wire

// ----- design/cau_sat.sv -----
// ----------------------------------------------------------------------------
// Saturating converter
// Turns a sign and a magnitude into a clamped two's complement value.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_sat #(
  parameter int W  = cau_pkg::CAU_DATA_WIDTH,
  parameter int MW = 2 * cau_pkg::CAU_DATA_WIDTH
) (
  input  wire logic          neg,
  input  wire logic [MW-1:0] mag,
  output logic      [W-1:0]  res,
  output logic               ovf
);

  localparam logic [MW-1:0] LIM_N = MW'(1) << (W - 1);
  localparam logic [MW-1:0] LIM_P = LIM_N - MW'(1);
  localparam logic [W-1:0]  SMIN  = W'(1) << (W - 1);

  logic [MW-1:0] neg_mag;

  always_comb begin
    neg_mag = -mag;
    if (neg) begin
      ovf = mag > LIM_N;
      res = ovf ? SMIN : neg_mag[W-1:0];
    end else begin
      ovf = mag > LIM_P;
      res = ovf ? ~SMIN : mag[W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/cau_front.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Operand capture, products, sums, sign split and rounding in five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
  parameter int W = cau_pkg::CAU_DATA_WIDTH,
  parameter int F = cau_pkg::CAU_FRAC_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            in_vld,
  input  wire logic [cau_pkg::IN_TDATA_W-1:0]  in_data,
  output cau_pkg::cau_ctl_t                    ctl_o,
  output logic [1:0][2*W+F-1:0]                dvd_o,
  output logic [2*W-1:0]                       den_o,
  output logic [2*W-1:0]                       pass_o
);

  localparam int PW = 2 * W;
  localparam int N  = 2 * W + F;
  localparam int RW = PW + F + 1;
  localparam int HALF_SH = (F > 0) ? F - 1 : 0;
  localparam logic [RW-1:0] HALF = (F > 0) ? (RW'(1) << HALF_SH) : '0;
  localparam logic [W-1:0]  SMIN = W'(1) << (W - 1);

  // Stage 1: operand capture
  logic                          s1_v_r;
  logic [cau_pkg::ACTION_W-1:0]  s1_act_r;
  logic signed [W-1:0]           s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_act_r <= in_data[cau_pkg::IN_ACT_LSB +: cau_pkg::ACTION_W];
      s1_ar_r  <= in_data[cau_pkg::IN_AR_LSB +: W];
      s1_ai_r  <= in_data[cau_pkg::IN_AI_LSB +: W];
      s1_br_r  <= in_data[cau_pkg::IN_BR_LSB +: W];
      s1_bi_r  <= in_data[cau_pkg::IN_BI_LSB +: W];
    end
  end

  // Stage 2: the six products and the plain sums
  logic                          s2_v_r;
  logic [cau_pkg::ACTION_W-1:0]  s2_act_r;
  logic signed [PW-1:0]          s2_prr_r, s2_pii_r, s2_pri_r, s2_pir_r;
  logic signed [PW-1:0]          s2_drr_r, s2_dii_r;
  logic signed [W:0]             s2_sumr_r, s2_sumi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_act_r  <= s1_act_r;
      s2_prr_r  <= s1_ar_r * s1_br_r;
      s2_pii_r  <= s1_ai_r * s1_bi_r;
      s2_pri_r  <= s1_ar_r * s1_bi_r;
      s2_pir_r  <= s1_ai_r * s1_br_r;
      s2_drr_r  <= s1_br_r * s1_br_r;
      s2_dii_r  <= s1_bi_r * s1_bi_r;
      s2_sumr_r <= (s1_act_r == cau_pkg::ACT_SUB) ? s1_ar_r - s1_br_r : s1_ar_r + s1_br_r;
      s2_sumi_r <= (s1_act_r == cau_pkg::ACT_SUB) ? s1_ai_r - s1_bi_r : s1_ai_r + s1_bi_r;
    end
  end

  // Stage 3: numerator sums, divisor, clamp of the plain sums
  logic                          s3_v_r;
  logic [cau_pkg::ACTION_W-1:0]  s3_act_r;
  logic signed [PW:0]            s3_nr_r, s3_ni_r;
  logic [PW-1:0]                 s3_den_r;
  logic [PW-1:0]                 s3_pass_r;
  logic                          s3_ovf_r;
  logic [PW:0]                   den_sum;
  logic                          ovf_sr, ovf_si;
  logic [W-1:0]                  sat_sr, sat_si;

  always_comb begin
    den_sum = {1'b0, s2_drr_r} + {1'b0, s2_dii_r};
    ovf_sr  = s2_sumr_r[W] != s2_sumr_r[W-1];
    ovf_si  = s2_sumi_r[W] != s2_sumi_r[W-1];
    sat_sr  = ovf_sr ? (s2_sumr_r[W] ? SMIN : ~SMIN) : s2_sumr_r[W-1:0];
    sat_si  = ovf_si ? (s2_sumi_r[W] ? SMIN : ~SMIN) : s2_sumi_r[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_act_r  <= s2_act_r;
      s3_den_r  <= den_sum[PW-1:0];
      s3_pass_r <= {sat_si, sat_sr};
      s3_ovf_r  <= ovf_sr | ovf_si;
      if (s2_act_r == cau_pkg::ACT_DIV) begin
        s3_nr_r <= s2_prr_r + s2_pii_r;
        s3_ni_r <= s2_pir_r - s2_pri_r;
      end else begin
        s3_nr_r <= s2_prr_r - s2_pii_r;
        s3_ni_r <= s2_pri_r + s2_pir_r;
      end
    end
  end

  // Stage 4: sign and magnitude
  logic                          s4_v_r;
  logic [cau_pkg::ACTION_W-1:0]  s4_act_r;
  logic                          s4_negr_r, s4_negi_r, s4_den0_r, s4_ovf_r;
  logic [PW-1:0]                 s4_magr_r, s4_magi_r, s4_den_r, s4_pass_r;
  logic signed [PW:0]            inv_r, inv_i;

  always_comb begin
    inv_r = -s3_nr_r;
    inv_i = -s3_ni_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_act_r  <= s3_act_r;
      s4_negr_r <= s3_nr_r[PW];
      s4_negi_r <= s3_ni_r[PW];
      s4_magr_r <= s3_nr_r[PW] ? inv_r[PW-1:0] : s3_nr_r[PW-1:0];
      s4_magi_r <= s3_ni_r[PW] ? inv_i[PW-1:0] : s3_ni_r[PW-1:0];
      s4_den_r  <= s3_den_r;
      s4_den0_r <= s3_den_r == '0;
      s4_pass_r <= s3_pass_r;
      s4_ovf_r  <= s3_ovf_r;
    end
  end

  // Stage 5: round the product, set up the divider
  logic [RW-1:0] rnd_r, rnd_i;
  logic [W-1:0]  mul_r, mul_i;
  logic          ovf_mr, ovf_mi;
  logic [cau_pkg::STATUS_W-1:0] stat;
  logic [PW-1:0] pass_sel;

  always_comb begin
    rnd_r = (RW'(s4_magr_r) + HALF) >> F;
    rnd_i = (RW'(s4_magi_r) + HALF) >> F;
  end

  cau_sat #(.W(W), .MW(RW)) u_sat_re (.neg(s4_negr_r), .mag(rnd_r), .res(mul_r), .ovf(ovf_mr));
  cau_sat #(.W(W), .MW(RW)) u_sat_im (.neg(s4_negi_r), .mag(rnd_i), .res(mul_i), .ovf(ovf_mi));

  always_comb begin
    pass_sel = s4_pass_r;
    case (s4_act_r)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
        stat = s4_ovf_r ? cau_pkg::STAT_OVF : cau_pkg::STAT_OK;
      end
      cau_pkg::ACT_MUL: begin
        stat     = (ovf_mr | ovf_mi) ? cau_pkg::STAT_OVF : cau_pkg::STAT_OK;
        pass_sel = {mul_i, mul_r};
      end
      cau_pkg::ACT_DIV: begin
        stat = s4_den0_r ? cau_pkg::STAT_DIVZ : cau_pkg::STAT_OK;
      end
      default: begin
        stat = cau_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o.vld    <= s4_v_r;
      ctl_o.is_div <= s4_act_r == cau_pkg::ACT_DIV;
      ctl_o.neg_re <= s4_negr_r;
      ctl_o.neg_im <= s4_negi_r;
      ctl_o.status <= stat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_o[0] <= N'(s4_magr_r) << F;
      dvd_o[1] <= N'(s4_magi_r) << F;
      den_o    <= s4_den_r;
      pass_o   <= pass_sel;
    end
  end

endmodule

`default_nettype wire

// ----- design/cau_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for the real and the imaginary numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_cell #(
  parameter int W = cau_pkg::CAU_DATA_WIDTH,
  parameter int F = cau_pkg::CAU_FRAC_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire cau_pkg::cau_ctl_t      ctl_i,
  input  wire logic [1:0][2*W+F-1:0]  dvd_i,
  input  wire logic [1:0][2*W-1:0]    rem_i,
  input  wire logic [1:0][W+1:0]      q_i,
  input  wire logic [1:0]             big_i,
  input  wire logic [2*W-1:0]         den_i,
  input  wire logic [2*W-1:0]         pass_i,
  output cau_pkg::cau_ctl_t           ctl_o,
  output logic [1:0][2*W+F-1:0]       dvd_o,
  output logic [1:0][2*W-1:0]         rem_o,
  output logic [1:0][W+1:0]           q_o,
  output logic [1:0]                  big_o,
  output logic [2*W-1:0]              den_o,
  output logic [2*W-1:0]              pass_o
);

  localparam int PW = 2 * W;
  localparam int N  = 2 * W + F;
  localparam int QW = W + 2;

  logic [1:0][PW-1:0] shf, rem_nxt;
  logic [1:0]         ge;

  // The partial remainder stays below the divisor, so its top bit is free.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      shf[l]     = {rem_i[l][PW-2:0], dvd_i[l][N-1]};
      ge[l]      = shf[l] >= den_i;
      rem_nxt[l] = ge[l] ? shf[l] - den_i : shf[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        dvd_o[l] <= {dvd_i[l][N-2:0], 1'b0};
        rem_o[l] <= rem_nxt[l];
        q_o[l]   <= {q_i[l][QW-2:0], ge[l]};
        big_o[l] <= big_i[l] | q_i[l][QW-1];
      end
      den_o  <= den_i;
      pass_o <= pass_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/cau_out.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit output stage
// Quotient rounding and clamping, result select, output register and skid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arithmetic_unit_core_macros.svh"

module cau_out #(
  parameter int W = cau_pkg::CAU_DATA_WIDTH,
  parameter int F = cau_pkg::CAU_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cau_pkg::cau_ctl_t                ctl_i,
  input  wire logic [1:0][2*W-1:0]              rem_i,
  input  wire logic [1:0][W+1:0]                q_i,
  input  wire logic [1:0]                       big_i,
  input  wire logic [2*W-1:0]                   den_i,
  input  wire logic [2*W-1:0]                   pass_i,
  input  wire logic                             out_tready,
  output logic                                  out_tvalid,
  output logic [cau_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  en
);

  localparam int QW = W + 2;
  localparam int FW = cau_pkg::FIELD_W;

  logic [1:0]            up;
  logic [1:0][QW:0]      qf, mag;
  logic [1:0][W-1:0]     dres;
  logic [1:0]            dovf;
  logic signed [W-1:0]   res_re, res_im;
  logic [cau_pkg::STATUS_W-1:0] stat;
  logic [cau_pkg::OUT_TDATA_W-1:0] fin_data;
  logic                  fin_v;

  // Round half away from zero on the magnitude; a quotient that ran past the
  // register is forced to all ones so that it saturates.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      up[l]  = rem_i[l] >= (den_i - rem_i[l]);
      qf[l]  = {1'b0, q_i[l]} + (QW+1)'(up[l]);
      mag[l] = big_i[l] ? '1 : qf[l];
    end
  end

  cau_sat #(.W(W), .MW(QW+1)) u_sat_re (.neg(ctl_i.neg_re), .mag(mag[0]), .res(dres[0]),
                                        .ovf(dovf[0]));
  cau_sat #(.W(W), .MW(QW+1)) u_sat_im (.neg(ctl_i.neg_im), .mag(mag[1]), .res(dres[1]),
                                        .ovf(dovf[1]));

  always_comb begin
    res_re = pass_i[W-1:0];
    res_im = pass_i[2*W-1:W];
    stat   = ctl_i.status;
    if (ctl_i.is_div) begin
      if (ctl_i.status == cau_pkg::STAT_DIVZ) begin
        res_re = '0;
        res_im = '0;
      end else begin
        res_re = dres[0];
        res_im = dres[1];
        stat   = (dovf[0] | dovf[1]) ? cau_pkg::STAT_OVF : cau_pkg::STAT_OK;
      end
    end
    fin_data = '0;
    fin_data[cau_pkg::OUT_RR_LSB +: FW] = FW'(res_re);
    fin_data[cau_pkg::OUT_RI_LSB +: FW] = FW'(res_im);
    fin_data[cau_pkg::OUT_STAT_LSB +: cau_pkg::STATUS_W] = stat;
  end

  logic                             out_v_r, skid_v_r;
  logic [cau_pkg::OUT_TDATA_W-1:0]  out_data_r, skid_data_r;

  // The pipeline only moves while the skid stage is empty.
  assign en    = !skid_v_r;
  assign fin_v = ctl_i.vld & en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r  <= skid_v_r | fin_v;
      skid_v_r <= 1'b0;
    end else if (fin_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_data_r <= skid_v_r ? skid_data_r : fin_data;
    end else if (fin_v) begin
      skid_data_r <= fin_data;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  `CAU_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r, "skid stage full with output empty")
  `CAU_ASSERT_NXT(a_skid_holds, skid_v_r && !out_tready, skid_v_r, "skid stage lost a result")
  `CAU_ASSERT_IMP(a_no_rsvd_status, out_v_r, out_data_r[cau_pkg::OUT_STAT_LSB +: 2] != cau_pkg::STAT_RSVD, "reserved status code")
  `CAU_ASSERT_IMP(a_divz_zero, out_v_r && (out_data_r[cau_pkg::OUT_STAT_LSB +: 2] == cau_pkg::STAT_DIVZ), out_data_r[63:0] == '0, "divide by zero with a non-zero result")

endmodule

`default_nettype wire

// ----- design/complex_arithmetic_unit_core.sv -----
// Throughput: one request per cycle while the output skid stage is empty; the divider is
// a chain of 2*DATA_WIDTH + FRAC_BITS cells, one quotient bit each, so every operation
// flows through it at full rate.
// Reset: synchronous, active low; clears all valid flags, the data path is not reset.
// ----------------------------------------------------------------------------
// Complex arithmetic unit core
// Complex add, subtract, multiply and divide on signed fixed-point operands,
// with rounding, saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_core #(
  parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
  parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: action[1:0], a_real[33:2], a_imag[65:34], b_real[97:66], b_imag[129:98]
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [cau_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: res_real[31:0], res_imag[63:32], status[65:64]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [cau_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int N  = 2 * W + F;
  localparam int QW = W + 2;

  logic en;

  cau_pkg::cau_ctl_t        ch_ctl [N+1];
  logic [N:0][1:0][N-1:0]   ch_dvd;
  logic [N:0][1:0][PW-1:0]  ch_rem;
  logic [N:0][1:0][QW-1:0]  ch_q;
  logic [N:0][1:0]          ch_big;
  logic [N:0][PW-1:0]       ch_den;
  logic [N:0][PW-1:0]       ch_pass;

  assign in_tready = en;

  cau_front #(.W(W), .F(F)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_tvalid),
    .in_data(in_tdata),
    .ctl_o  (ch_ctl[0]),
    .dvd_o  (ch_dvd[0]),
    .den_o  (ch_den[0]),
    .pass_o (ch_pass[0])
  );

  assign ch_rem[0] = '0;
  assign ch_q[0]   = '0;
  assign ch_big[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    cau_div_cell #(.W(W), .F(F)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ch_ctl[i]),
      .dvd_i (ch_dvd[i]),
      .rem_i (ch_rem[i]),
      .q_i   (ch_q[i]),
      .big_i (ch_big[i]),
      .den_i (ch_den[i]),
      .pass_i(ch_pass[i]),
      .ctl_o (ch_ctl[i+1]),
      .dvd_o (ch_dvd[i+1]),
      .rem_o (ch_rem[i+1]),
      .q_o   (ch_q[i+1]),
      .big_o (ch_big[i+1]),
      .den_o (ch_den[i+1]),
      .pass_o(ch_pass[i+1])
    );
  end

  cau_out #(.W(W), .F(F)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ch_ctl[N]),
    .rem_i     (ch_rem[N]),
    .q_i       (ch_q[N]),
    .big_i     (ch_big[N]),
    .den_i     (ch_den[N]),
    .pass_i    (ch_pass[N]),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .en        (en)
  );

endmodule

`default_nettype wire

// ----- bench/tb_complex_arithmetic_unit_core.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit core testbench
// Drives operand requests through the input stream with random gaps, and
// predicts each complex sum, difference, product or quotient. It compares
// every result request field by field with the oldest prediction, under
// random back-pressure on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_complex_arithmetic_unit_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 120;

  typedef struct {
    logic [cau_pkg::FIELD_W-1:0]  re;
    logic [cau_pkg::FIELD_W-1:0]  im;
    logic [cau_pkg::STATUS_W-1:0] st;
  } cplx_res_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [cau_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [cau_pkg::OUT_TDATA_W-1:0] out_tdata;

  cplx_res_t pending_q[$];
  int        mismatches;
  int        cycle_cnt;
  int        stall_left;
  bit        idle_en;

  complex_arithmetic_unit_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clamp a sign/magnitude component to the 32-bit range.
  function automatic logic [cau_pkg::FIELD_W-1:0] clamp_part(input bit neg,
                                                              input logic [127:0] mag,
                                                              inout bit ovf);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin
      mag = lim;
      ovf = 1'b1;
    end
    return neg ? cau_pkg::FIELD_W'(-mag) : cau_pkg::FIELD_W'(mag);
  endfunction

  // Rounded quotient mag * 2^16 / den, ties upward; huge values capped at 2^40.
  function automatic logic [127:0] round_quot(input logic [127:0] mag,
                                               input logic [127:0] den);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] rem;
    num = mag << cau_pkg::CAU_FRAC_BITS;
    q   = num / den;
    if (q >= (128'd1 << 40))
      return 128'd1 << 40;
    rem = num - q * den;
    if (rem >= den - rem)
      q = q + 1;
    return q;
  endfunction

  function automatic cplx_res_t predict_complex(input logic [cau_pkg::ACTION_W-1:0] act,
                                                input logic signed [31:0] ar,
                                                input logic signed [31:0] ai,
                                                input logic signed [31:0] br,
                                                input logic signed [31:0] bi);
    logic signed [127:0] xr;
    logic signed [127:0] xi;
    logic signed [127:0] den;
    logic [127:0]        half;
    logic [127:0]        mr;
    logic [127:0]        mi;
    bit                  ovf;
    cplx_res_t           r;
    ovf  = 1'b0;
    half = 128'd1 << (cau_pkg::CAU_FRAC_BITS - 1);
    r.st = cau_pkg::STAT_OK;
    r.re = '0;
    r.im = '0;
    case (act)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
        xr = (act == cau_pkg::ACT_ADD) ? 128'(ar) + 128'(br) : 128'(ar) - 128'(br);
        xi = (act == cau_pkg::ACT_ADD) ? 128'(ai) + 128'(bi) : 128'(ai) - 128'(bi);
        r.re = clamp_part(xr < 0, xr < 0 ? -xr : xr, ovf);
        r.im = clamp_part(xi < 0, xi < 0 ? -xi : xi, ovf);
      end
      cau_pkg::ACT_MUL: begin
        xr = 128'(ar) * 128'(br) - 128'(ai) * 128'(bi);
        xi = 128'(ar) * 128'(bi) + 128'(ai) * 128'(br);
        mr = xr < 0 ? -xr : xr;
        mi = xi < 0 ? -xi : xi;
        r.re = clamp_part(xr < 0, (mr + half) >> cau_pkg::CAU_FRAC_BITS, ovf);
        r.im = clamp_part(xi < 0, (mi + half) >> cau_pkg::CAU_FRAC_BITS, ovf);
      end
      default: begin
        den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
        if (den == 0) begin
          r.st = cau_pkg::STAT_DIVZ;
        end else begin
          xr = 128'(ar) * 128'(br) + 128'(ai) * 128'(bi);
          xi = 128'(ai) * 128'(br) - 128'(ar) * 128'(bi);
          mr = xr < 0 ? -xr : xr;
          mi = xi < 0 ? -xi : xi;
          r.re = clamp_part(xr < 0, round_quot(mr, den), ovf);
          r.im = clamp_part(xi < 0, round_quot(mi, den), ovf);
        end
      end
    endcase
    if (ovf)
      r.st = cau_pkg::STAT_OVF;
    return r;
  endfunction

  // Accepted operand requests feed the prediction store.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      pending_q.push_back(predict_complex(
        in_tdata[cau_pkg::IN_ACT_LSB +: cau_pkg::ACTION_W],
        in_tdata[cau_pkg::IN_AR_LSB +: cau_pkg::FIELD_W],
        in_tdata[cau_pkg::IN_AI_LSB +: cau_pkg::FIELD_W],
        in_tdata[cau_pkg::IN_BR_LSB +: cau_pkg::FIELD_W],
        in_tdata[cau_pkg::IN_BI_LSB +: cau_pkg::FIELD_W]));
  end

  always @(posedge clk) begin
    cplx_res_t e;
    logic [cau_pkg::FIELD_W-1:0]  got_re;
    logic [cau_pkg::FIELD_W-1:0]  got_im;
    logic [cau_pkg::STATUS_W-1:0] got_st;
    got_re = out_tdata[cau_pkg::OUT_RR_LSB +: cau_pkg::FIELD_W];
    got_im = out_tdata[cau_pkg::OUT_RI_LSB +: cau_pkg::FIELD_W];
    got_st = out_tdata[cau_pkg::OUT_STAT_LSB +: cau_pkg::STATUS_W];
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: re=%h im=%h status=%0d", got_re, got_im, got_st);
      end else begin
        e = pending_q.pop_front();
        if (got_re !== e.re || got_im !== e.im || got_st !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected re=%h im=%h status=%0d, got re=%h im=%h status=%0d",
                     e.re, e.im, e.st, got_re, got_im, got_st);
        end
      end
    end
  end

  // Output back-pressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_op(input logic [cau_pkg::ACTION_W-1:0] act, input logic [31:0] ar,
                         input logic [31:0] ai, input logic [31:0] br,
                         input logic [31:0] bi);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, bi, br, ai, ar, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Mostly moderate values so that products and quotients stay in range.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3, 4: return $urandom;
      5: return 32'($signed($urandom_range(0, 255)) - 128) << 16;
      default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
    endcase
  endfunction

  task automatic test_directed();
    send_op(cau_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_op(cau_pkg::ACT_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000);
    send_op(cau_pkg::ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_op(cau_pkg::ACT_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_op(cau_pkg::ACT_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000);
    send_op(cau_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_op(cau_pkg::ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    // Exact half of a least significant bit rounds away from zero.
    send_op(cau_pkg::ACT_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0);
    send_op(cau_pkg::ACT_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0);
    send_op(cau_pkg::ACT_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_op(cau_pkg::ACT_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_op(cau_pkg::ACT_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_op(cau_pkg::ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
    send_op(cau_pkg::ACT_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_op(cau_pkg::ACT_DIV, 32'h0000_0001, 32'h0, 32'h0006_0000, 32'h0);
    send_op(cau_pkg::ACT_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    send_op(cau_pkg::ACT_DIV, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
  endtask

  task automatic test_random(input int n);
    repeat (n)
      send_op(cau_pkg::ACTION_W'($urandom_range(0, 3)), pick_operand(), pick_operand(),
              pick_operand(), pick_operand());
  endtask

  // Hold off the sender until the pipeline is empty, then carry on.
  task automatic test_drain_pause();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    test_random(50);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    mismatches = 0;
    cycle_cnt  = 0;
    stall_left = 0;
    idle_en    = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(800);
    test_drain_pause();
    test_random(650);
    idle_en = 1'b0;
    test_random(200);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+design
design/cau_pkg.sv
design/cau_sat.sv
design/cau_front.sv
design/cau_div_cell.sv
design/cau_out.sv
design/complex_arithmetic_unit_core.sv
bench/tb_complex_arithmetic_unit_core.sv
